/* rtl/trm_pkg.sv */
// ----------------------------------------------------------------------------
// trm_pkg
// Shared types and constants for the tiny register machine core: opcodes,
// the decoded instruction word and the packed result word.
// ----------------------------------------------------------------------------
`default_nettype none

package trm_pkg;

    localparam int INSTR_W   = 16;
    localparam int DATA_W    = 8;
    localparam int FLD_W     = 4;
    localparam int IMM_W     = 8;
    localparam int PC_W      = 8;
    localparam int CFG_W     = 9;
    localparam int CFG_IDX_W = 1;
    localparam int Q_DEPTH   = 2;

    // field positions inside the instruction word
    localparam int OPC_LSB   = 12;
    localparam int FLD_D_LSB = 8;
    localparam int FLD_B_LSB = 4;
    localparam int FLD_A_LSB = 0;
    localparam int IMM_LSB   = 0;
    localparam int JMP_LSB   = 4;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_OVF_LIMIT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_UNF_LIMIT = 1'b1;

    localparam logic [CFG_W-1:0] OVF_LIMIT_RST = 9'd255;
    localparam logic [CFG_W-1:0] UNF_LIMIT_RST = 9'd0;

    typedef enum logic [FLD_W-1:0] {
        OP_NOP   = 4'd0,
        OP_ADD   = 4'd1,
        OP_SUB   = 4'd2,
        OP_LOAD  = 4'd3,
        OP_LDI   = 4'd4,
        OP_STORE = 4'd5,
        OP_CMP   = 4'd6,
        OP_HALT  = 4'd7,
        OP_JMP   = 4'd8
    } t_op;

    typedef struct packed {
        t_op              op;
        logic [FLD_W-1:0] rd;
        logic [FLD_W-1:0] ra;
        logic [FLD_W-1:0] rb;
        logic [IMM_W-1:0] imm;
        logic [PC_W-1:0]  jaddr;
    } t_dec;

    // lowest bit first: next_pc, halted, equal, overflow, underflow, written
    typedef struct packed {
        logic [3:0]        pad;
        logic [DATA_W-1:0] written_value;
        logic              underflow_flag;
        logic              overflow_flag;
        logic              equal_flag;
        logic              halted;
        logic [PC_W-1:0]   next_pc;
    } t_result;

    localparam int OUT_W = $bits(t_result);

endpackage

`default_nettype wire

/* rtl/trm_front.sv */
// ----------------------------------------------------------------------------
// trm_front
// Accepts instruction words and decodes them into operand indexes and
// immediates for the execution side.
// ----------------------------------------------------------------------------
`default_nettype none

module trm_front (
    input  wire logic                       i_s_axis_tvalid,
    output logic                            o_s_axis_tready,
    input  wire logic [trm_pkg::INSTR_W-1:0] i_s_axis_tdata,  // instr_word
    input  wire logic                       i_q_full,
    output logic                            o_q_push,
    output trm_pkg::t_dec                   o_q_item
);
    import trm_pkg::*;

    logic [FLD_W-1:0] raw_op;
    t_op              op;

    assign o_s_axis_tready = !i_q_full;
    assign o_q_push        = i_s_axis_tvalid && !i_q_full;
    assign raw_op          = i_s_axis_tdata[OPC_LSB +: FLD_W];

    always_comb begin
        // undefined opcodes fold into nop
        if (raw_op > FLD_W'(OP_JMP)) begin
            op = OP_NOP;
        end else begin
            op = t_op'(raw_op);
        end
        o_q_item.op    = op;
        o_q_item.rd    = i_s_axis_tdata[FLD_D_LSB +: FLD_W];
        o_q_item.ra    = (op == OP_CMP || op == OP_STORE)
                       ? i_s_axis_tdata[FLD_D_LSB +: FLD_W]
                       : i_s_axis_tdata[FLD_A_LSB +: FLD_W];
        o_q_item.rb    = i_s_axis_tdata[FLD_B_LSB +: FLD_W];
        o_q_item.imm   = i_s_axis_tdata[IMM_LSB +: IMM_W];
        o_q_item.jaddr = i_s_axis_tdata[JMP_LSB +: PC_W];
    end

endmodule

`default_nettype wire

/* rtl/trm_queue.sv */
// ----------------------------------------------------------------------------
// trm_queue
// Short queue of decoded words between the front and the execution side.
// ----------------------------------------------------------------------------
`default_nettype none

module trm_queue (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_push,
    input  trm_pkg::t_dec i_item,
    output logic         o_full,
    input  wire logic    i_pop,
    output logic         o_valid,
    output trm_pkg::t_dec o_item
);
    import trm_pkg::*;

    localparam int PTR_W = $clog2(Q_DEPTH);
    localparam int CNT_W = $clog2(Q_DEPTH + 1);

    t_dec             r_mem [Q_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;
    logic             do_pop;

    assign o_full  = (r_count == CNT_W'(Q_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_item  = r_mem[r_rd_ptr];
    assign do_pop  = i_pop && o_valid;

    always_comb begin
        n_wr_ptr = i_push ? PTR_W'(r_wr_ptr + 1'b1) : r_wr_ptr;
        n_rd_ptr = do_pop ? PTR_W'(r_rd_ptr + 1'b1) : r_rd_ptr;
        case ({i_push, do_pop})
            2'b10:   n_count = CNT_W'(r_count + 1'b1);
            2'b01:   n_count = CNT_W'(r_count - 1'b1);
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

endmodule

`default_nettype wire

/* rtl/trm_back.sv */
// ----------------------------------------------------------------------------
// trm_back
// Execution side: operand read stage with bypass from the executing word,
// then execute into the output register, updating pc, flags, bank and memory.
// ----------------------------------------------------------------------------
`default_nettype none

module trm_back #(
    parameter int NUM_REGS  = 16,
    parameter int MEM_DEPTH = 256
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_cfg_we,
    input  wire logic [trm_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [trm_pkg::CFG_W-1:0]     i_cfg_data,
    input  wire logic                         i_q_valid,
    input  trm_pkg::t_dec                      i_q_item,
    output logic                              o_q_pop,
    output logic                              o_m_axis_tvalid,
    input  wire logic                         i_m_axis_tready,
    output trm_pkg::t_result                   o_result
);
    import trm_pkg::*;

    localparam int RIDX_W = $clog2(NUM_REGS);
    localparam int MIDX_W = $clog2(MEM_DEPTH);

    // register bank and data memory, entries read as zero until written
    logic [DATA_W-1:0]    r_bank [NUM_REGS];
    logic [NUM_REGS-1:0]  r_bank_vld;
    logic [DATA_W-1:0]    r_dmem [MEM_DEPTH];
    logic [MEM_DEPTH-1:0] r_dmem_vld;

    logic [CFG_W-1:0] r_ovf_lim;
    logic [CFG_W-1:0] r_unf_lim;

    // operand stage
    logic              r_s1_valid;
    t_dec              r_s1;
    logic [DATA_W-1:0] r_rda, r_rdb, r_rdm;

    // architectural state
    logic [PC_W-1:0] r_pc, n_pc;
    logic            r_halt, n_halt;
    logic            r_eq, n_eq;
    logic            r_ovf, n_ovf;
    logic            r_unf, n_unf;

    logic    r_out_valid;
    t_result r_result;

    logic s1_move, s1_load;
    logic ra_ok, rb_ok, rm_ok, rd_ok, st_ok;
    logic [RIDX_W-1:0] ra_idx, rb_idx;
    logic [MIDX_W-1:0] rm_idx;

    logic [DATA_W:0]     sum;
    logic signed [DATA_W+1:0] diff;
    logic signed [DATA_W+1:0] unf_lim_ext;
    logic [PC_W-1:0]     pc_base;
    logic [DATA_W-1:0]   x_wdata;
    logic                reg_wr, mem_wr;
    logic                x_reg_we, x_mem_we;

    assign s1_move = r_s1_valid && (!r_out_valid || i_m_axis_tready);
    assign s1_load = i_q_valid && (!r_s1_valid || s1_move);
    assign o_q_pop = s1_load;

    assign ra_ok  = 32'(i_q_item.ra) < NUM_REGS;
    assign rb_ok  = 32'(i_q_item.rb) < NUM_REGS;
    assign rm_ok  = 32'(i_q_item.imm) < MEM_DEPTH;
    assign ra_idx = i_q_item.ra[RIDX_W-1:0];
    assign rb_idx = i_q_item.rb[RIDX_W-1:0];
    assign rm_idx = i_q_item.imm[MIDX_W-1:0];

    assign rd_ok  = 32'(r_s1.rd) < NUM_REGS;
    assign st_ok  = 32'(r_s1.imm) < MEM_DEPTH;

    assign unf_lim_ext = $signed({r_unf_lim[CFG_W-1], r_unf_lim});

    always_comb begin
        sum     = {1'b0, r_rda} + {1'b0, r_rdb};
        diff    = $signed({2'b00, r_rda}) - $signed({2'b00, r_rdb});
        n_halt  = r_halt;
        n_eq    = r_eq;
        n_ovf   = r_ovf;
        n_unf   = r_unf;
        pc_base = r_pc;
        n_pc    = r_pc;
        x_wdata = '0;
        reg_wr  = 1'b0;
        mem_wr  = 1'b0;
        if (!r_halt) begin
            unique case (r_s1.op)
                OP_ADD: begin
                    x_wdata = sum[DATA_W-1:0];
                    reg_wr  = 1'b1;
                    if (sum > r_ovf_lim) begin
                        n_ovf = 1'b1;
                    end
                end
                OP_SUB: begin
                    x_wdata = diff[DATA_W-1:0];
                    reg_wr  = 1'b1;
                    if (diff < unf_lim_ext) begin
                        n_unf = 1'b1;
                    end
                end
                OP_LOAD: begin
                    x_wdata = r_rdm;
                    reg_wr  = 1'b1;
                end
                OP_LDI: begin
                    x_wdata = r_s1.imm;
                    reg_wr  = 1'b1;
                end
                OP_STORE: begin
                    x_wdata = r_rda;
                    mem_wr  = 1'b1;
                end
                OP_CMP:  n_eq    = (r_rda == r_rdb);
                OP_HALT: n_halt  = 1'b1;
                OP_JMP:  pc_base = r_s1.jaddr;
                default: ;
            endcase
            n_pc = PC_W'(pc_base + 1'b1);
        end
    end

    assign x_reg_we = s1_move && reg_wr && rd_ok;
    assign x_mem_we = s1_move && mem_wr && st_ok;

    // operand reads, bypassing the word that executes on the same edge
    always_ff @(posedge i_clk) begin
        if (s1_load) begin
            r_s1 <= i_q_item;
            if (x_reg_we && r_s1.rd == i_q_item.ra) begin
                r_rda <= x_wdata;
            end else if (ra_ok && r_bank_vld[ra_idx]) begin
                r_rda <= r_bank[ra_idx];
            end else begin
                r_rda <= '0;
            end
            if (x_reg_we && r_s1.rd == i_q_item.rb) begin
                r_rdb <= x_wdata;
            end else if (rb_ok && r_bank_vld[rb_idx]) begin
                r_rdb <= r_bank[rb_idx];
            end else begin
                r_rdb <= '0;
            end
            if (x_mem_we && r_s1.imm == i_q_item.imm) begin
                r_rdm <= x_wdata;
            end else if (rm_ok && r_dmem_vld[rm_idx]) begin
                r_rdm <= r_dmem[rm_idx];
            end else begin
                r_rdm <= '0;
            end
        end
        if (x_reg_we) begin
            r_bank[r_s1.rd[RIDX_W-1:0]] <= x_wdata;
        end
        if (x_mem_we) begin
            r_dmem[r_s1.imm[MIDX_W-1:0]] <= x_wdata;
        end
        if (s1_move) begin
            r_result.pad            <= '0;
            r_result.written_value  <= x_wdata;
            r_result.underflow_flag <= n_unf;
            r_result.overflow_flag  <= n_ovf;
            r_result.equal_flag     <= n_eq;
            r_result.halted         <= n_halt;
            r_result.next_pc        <= n_pc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bank_vld  <= '0;
            r_dmem_vld  <= '0;
            r_ovf_lim   <= OVF_LIMIT_RST;
            r_unf_lim   <= UNF_LIMIT_RST;
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_pc        <= '0;
            r_halt      <= 1'b0;
            r_eq        <= 1'b0;
            r_ovf       <= 1'b0;
            r_unf       <= 1'b0;
        end else begin
            if (x_reg_we) begin
                r_bank_vld[r_s1.rd[RIDX_W-1:0]] <= 1'b1;
            end
            if (x_mem_we) begin
                r_dmem_vld[r_s1.imm[MIDX_W-1:0]] <= 1'b1;
            end
            if (i_cfg_we) begin
                if (i_cfg_idx == CFG_OVF_LIMIT) begin
                    r_ovf_lim <= i_cfg_data;
                end
                if (i_cfg_idx == CFG_UNF_LIMIT) begin
                    r_unf_lim <= i_cfg_data;
                end
            end
            if (s1_load) begin
                r_s1_valid <= 1'b1;
            end else if (s1_move) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_move) begin
                r_out_valid <= 1'b1;
                r_pc        <= n_pc;
                r_halt      <= n_halt;
                r_eq        <= n_eq;
                r_ovf       <= n_ovf;
                r_unf       <= n_unf;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_result        = r_result;

    a_halt_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_halt |=> r_halt)
        else $error("halt flag cleared without reset");

    a_no_write_halted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_halt |-> (!x_reg_we && !x_mem_we))
        else $error("state written while halted");

    a_exec_fills_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s1_move |=> r_out_valid)
        else $error("executed word did not reach the output register");

    a_pc_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s1_move && !r_halt && r_s1.op != OP_JMP) |=> r_pc == PC_W'($past(r_pc) + 1'b1))
        else $error("program counter did not advance by one");

endmodule

`default_nettype wire

/* rtl/tiny_register_machine_core.sv */
// ----------------------------------------------------------------------------
// tiny_register_machine_core
// Executes one 16-bit instruction word per input word and returns the
// machine status after it as one output word.
//
// Input stream: tdata carries the instruction word. Output stream: one word
// per input word, in order, with next_pc, the halt/equal/overflow/underflow
// flags and the value written by the instruction (zero if none).
// Configuration: i_cfg_we writes i_cfg_data into register i_cfg_idx
// (0 overflow limit, 1 underflow limit); write only while the core is idle.
// Each accepted word passes through the queue, the operand read register and
// the output register. Throughput: one instruction per cycle unless the
// receiver stalls; a read-after-write on the register bank or data memory
// is bypassed from the executing word, so no bubbles.
// Reset clears the registers, data memory (per-entry valid bits), program
// counter and flags, sets the limits to 255 and 0 and then accepts input.
// When the receiver stalls, the output register holds its word, the operand
// stage and the two-entry queue fill, and then tready drops.
// ----------------------------------------------------------------------------
`default_nettype none

module tiny_register_machine_core #(
    parameter int NUM_REGS  = 16,
    parameter int MEM_DEPTH = 256
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_we,
    input  wire logic [trm_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [trm_pkg::CFG_W-1:0]      i_cfg_data,
    input  wire logic                          i_s_axis_tvalid,
    output logic                               o_s_axis_tready,
    // instr_word
    input  wire logic [trm_pkg::INSTR_W-1:0]    i_s_axis_tdata,
    output logic                               o_m_axis_tvalid,
    input  wire logic                          i_m_axis_tready,
    // next_pc, halted, equal_flag, overflow_flag, underflow_flag,
    // written_value, zero fill
    output logic [trm_pkg::OUT_W-1:0]           o_m_axis_tdata
);
    import trm_pkg::*;

    logic    q_push, q_full, q_pop, q_valid;
    t_dec    push_item, head_item;
    t_result result;

    trm_front u_front (
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_q_full        (q_full),
        .o_q_push        (q_push),
        .o_q_item        (push_item)
    );

    trm_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_item  (push_item),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_item  (head_item)
    );

    trm_back #(
        .NUM_REGS  (NUM_REGS),
        .MEM_DEPTH (MEM_DEPTH)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data),
        .i_q_valid       (q_valid),
        .i_q_item        (head_item),
        .o_q_pop         (q_pop),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_result        (result)
    );

    assign o_m_axis_tdata = result;

endmodule

`default_nettype wire
